FILE: rtl/frs_pkg.sv
// Package for the frame replacement selector.
// Holds the frame count, field widths, policy codes, state codes and the scan control struct.
// No dependencies.
package frs_pkg;

  // Number of physical frames tracked by the selector.
  localparam int unsigned NUM_FRAMES = 16;

  // Index width for one frame, and counter width that can also hold NUM_FRAMES.
  localparam int unsigned FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CNT_W   = FRAME_W + 1;

  // Field widths.
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned ENTRY_W  = COUNT_W + STAMP_W;

  // Saturation limits.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
  localparam logic [STAMP_W-1:0] STAMP_LIMIT = 32'h7FFF_FFFF;

  // Replacement policy codes.
  typedef enum logic [1:0] {
    POL_LEAST_RECENT = 2'd0,
    POL_MOST_RECENT  = 2'd1,
    POL_LEAST_USED   = 2'd2,
    POL_MOST_USED    = 2'd3
  } policy_e;

  // Request modes.
  typedef enum logic {
    MODE_REPLACE = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic sample;  // a frame key is presented this cycle
    logic first;   // the presented key belongs to frame 0
  } scan_ctrl_t;

endpackage

FILE: rtl/frs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the per-frame use count and load stamp table. No dependencies.
module frs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/frs_scan.sv
// Shared compare unit of the frame replacement selector.
// Keeps the best key and frame index seen so far during a scan; uses frs_pkg.
module frs_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  frs_pkg::scan_ctrl_t             ctrl_i,
  input  logic [1:0]                      policy_i,
  input  logic [frs_pkg::COUNT_W-1:0]     use_count_i,
  input  logic [frs_pkg::STAMP_W-1:0]     load_stamp_i,
  input  logic [frs_pkg::FRAME_W-1:0]     frame_i,
  output logic [frs_pkg::FRAME_W-1:0]     best_frame_o
);
  import frs_pkg::*;

  logic               by_stamp;
  logic               want_max;
  logic [STAMP_W-1:0] key;
  logic [STAMP_W-1:0] best_key_q, best_key_d;
  logic [FRAME_W-1:0] best_frame_q, best_frame_d;
  logic               take;

  // Select the key under the policy: stamp for recency, use count otherwise.
  assign by_stamp = (policy_i == POL_LEAST_RECENT) || (policy_i == POL_MOST_RECENT);
  assign want_max = (policy_i == POL_MOST_RECENT) || (policy_i == POL_MOST_USED);
  assign key      = by_stamp ? load_stamp_i : STAMP_W'(use_count_i);

  // One comparator; strict compare keeps ties on the lower index.
  always_comb begin
    take = 1'b0;
    if (ctrl_i.sample) begin
      if (ctrl_i.first) begin
        take = 1'b1;
      end else if (want_max) begin
        take = key > best_key_q;
      end else begin
        take = key < best_key_q;
      end
    end
    best_key_d   = take ? key : best_key_q;
    best_frame_d = take ? frame_i : best_frame_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_frame_q <= '0;
    end else begin
      best_frame_q <= best_frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
  end

  assign best_frame_o = best_frame_q;

endmodule

FILE: rtl/frame_replacement_selector.sv
// Top level of the frame replacement selector: sequencer, valid bits, stamp counter.
// Depends on frs_pkg, frs_ram and frs_scan.
//
// A replace transaction passes from acceptance through the scan state and the
// write state until the block is ready again: the sequencer reads one frame a
// cycle from the counter table through its single read port, the shared
// comparator folds each key into the running best in the cycle after its read,
// and the write state writes the victim's new use count and load stamp back. A release
// transaction completes in the accepting cycle and the block stays ready. The
// result is held in an output register; a write-back waits only if the previous
// result has not yet been taken. Frames start out and return to zero counters by
// means of per-frame valid bits, so no clearing pass is needed after reset.
module frame_replacement_selector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_policy_i,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [frs_pkg::IDX_W-1:0]     frame_index_i,
  input  logic [frs_pkg::COUNT_W-1:0]   carried_use_count_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [frs_pkg::IDX_W-1:0]     victim_frame_o
);
  import frs_pkg::*;

  state_e              state_q, state_d;
  logic [1:0]          policy_q;
  logic [NUM_FRAMES-1:0] valid_q;
  logic [STAMP_W-1:0]  stamp_q;
  logic [COUNT_W-1:0]  new_count_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                rd_vld_q;
  logic [FRAME_W-1:0]  rd_frame_q;
  logic                ent_vld_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    victim_q;

  logic                in_fire;
  logic                issue;
  logic                last_cmp;
  logic                write_go;
  logic                rel_hit;
  logic [FRAME_W-1:0]  rel_frame;
  logic [FRAME_W-1:0]  best_frame;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [ENTRY_W-1:0]  wr_entry;
  logic [COUNT_W-1:0]  rd_count;
  logic [STAMP_W-1:0]  rd_stamp;
  scan_ctrl_t          scan_ctrl;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign victim_frame_o = victim_q;

  // Scan progress.
  assign issue    = (state_q == ST_SCAN) && (cnt_q < CNT_W'(NUM_FRAMES));
  assign last_cmp = rd_vld_q && (rd_frame_q == FRAME_W'(NUM_FRAMES - 1));
  assign write_go = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  // Release target, ignored when beyond the frame count.
  assign rel_hit   = (32'(frame_index_i) < 32'(NUM_FRAMES));
  assign rel_frame = FRAME_W'(frame_index_i);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (mode_i == MODE_REPLACE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_cmp) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (write_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_LEAST_RECENT;
      valid_q     <= '0;
      stamp_q     <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_policy_i;
      end
      if (in_fire) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // A released frame reads as zero counters from now on.
      if (in_fire && (mode_i == MODE_RELEASE) && rel_hit) begin
        valid_q[rel_frame] <= 1'b0;
      end
      if (write_go) begin
        valid_q[best_frame] <= 1'b1;
        if (stamp_q < STAMP_LIMIT) begin
          stamp_q <= stamp_q + STAMP_W'(1);
        end
      end
      if (write_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_count_q <= (carried_use_count_i == COUNT_LIMIT) ? COUNT_LIMIT
                                                          : carried_use_count_i + COUNT_W'(1);
    end
    rd_frame_q <= cnt_q[FRAME_W-1:0];
    ent_vld_q  <= valid_q[cnt_q[FRAME_W-1:0]];
    if (write_go) begin
      victim_q <= IDX_W'(best_frame);
    end
  end

  // Counter table: use count in the upper bits, load stamp in the lower.
  assign wr_entry = {new_count_q, stamp_q};

  frs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_FRAMES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (write_go),
    .waddr_i(best_frame),
    .wdata_i(wr_entry),
    .raddr_i(cnt_q[FRAME_W-1:0]),
    .rdata_o(rd_entry)
  );

  // An entry never loaded since reset or release reads as zero.
  assign rd_count = ent_vld_q ? rd_entry[ENTRY_W-1:STAMP_W] : '0;
  assign rd_stamp = ent_vld_q ? rd_entry[STAMP_W-1:0] : '0;

  assign scan_ctrl.sample = rd_vld_q;
  assign scan_ctrl.first  = (rd_frame_q == '0);

  frs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .policy_i    (policy_q),
    .use_count_i (rd_count),
    .load_stamp_i(rd_stamp),
    .frame_i     (rd_frame_q),
    .best_frame_o(best_frame)
  );

endmodule

FILE: rtl/frs_checker.sv
// Port-level checker for the frame replacement selector, bound to the top level.
// Depends on frs_pkg and frame_replacement_selector.
module frs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          mode_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [frs_pkg::IDX_W-1:0]     victim_frame_o
);
  import frs_pkg::*;

  // A stalled result keeps its frame.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(victim_frame_o))
    else $error("result changed while stalled");

  // A replace transaction keeps the block busy while it scans.
  a_replace_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_REPLACE) |=> !in_ready_o)
    else $error("ready after replace acceptance");

  // A release transaction finishes at once.
  a_release_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_RELEASE) |=> in_ready_o)
    else $error("not ready after release");

  // A replace result cannot appear in the cycle after acceptance.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_REPLACE) && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind frame_replacement_selector frs_checker u_frs_checker (.*);
